// ===== src/pitp_pkg.sv =====
// ---------------------------------------------------------------------------
// pitp_pkg: shared types and constants for the prefixed integer text parser
// item layouts, error codes, radix codes and the scan snapshot
// ---------------------------------------------------------------------------
package pitp_pkg;

    localparam int DIGIT_BUFFER_SIZE = 128;

    // error codes; where several apply, the one checked first in pitp_finish wins
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_EMPTY      = 3'd1;
    localparam logic [2:0] ERR_NO_DIGITS  = 3'd2;
    localparam logic [2:0] ERR_PREFIX     = 3'd3;
    localparam logic [2:0] ERR_JUNK       = 3'd4;
    localparam logic [2:0] ERR_TOO_LONG   = 3'd5;
    localparam logic [2:0] ERR_BAD_DIGIT  = 3'd6;
    localparam logic [2:0] ERR_RANGE      = 3'd7;

    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_BIN = 2'd1;
    localparam logic [1:0] RADIX_OCT = 2'd2;
    localparam logic [1:0] RADIX_HEX = 2'd3;

    typedef struct packed {
        logic [7:0] text_char;
        logic       last_char;
    } char_item_t;

    typedef struct packed {
        logic               parse_ok;
        logic signed [63:0] parsed_value;
        logic [4:0]         detected_radix;
        logic [2:0]         error_code;
    } result_item_t;

    // state of one field as it stood after its final character
    typedef struct packed {
        logic        early_done;
        logic [2:0]  early_code;
        logic        negative;
        logic [1:0]  radix_code;
        logic [63:0] magnitude;
        logic        overflow;
        logic        count_zero;
        logic        count_long;
        logic        bad_digit;
        logic        junk;
    } scan_snap_t;

    function automatic logic [4:0] radix_value(input logic [1:0] code);
        logic [4:0] rv;
        unique case (code)
            RADIX_BIN: rv = 5'd2;
            RADIX_OCT: rv = 5'd8;
            RADIX_HEX: rv = 5'd16;
            default:   rv = 5'd10;
        endcase
        return rv;
    endfunction

endpackage

// ===== src/pitp_scan.sv =====
// ---------------------------------------------------------------------------
// pitp_scan: per-character scanner
// phase machine, digit accumulator and sticky flags; snapshots the field at
// its final character and returns to the start state
// ---------------------------------------------------------------------------
module pitp_scan (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  pitp_pkg::char_item_t item,
    output pitp_pkg::scan_snap_t snap
);
    import pitp_pkg::*;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_SIGNED,
        PH_ZERO,
        PH_PREFIX,
        PH_RUN,
        PH_TRAIL
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        negative_reg, negative_next;
    logic [1:0]  radix_reg, radix_next;
    logic [63:0] acc_reg, acc_next;
    logic        overflow_reg, overflow_next;
    logic [7:0]  count_reg, count_next;
    logic        bad_reg, bad_next;
    logic        junk_reg, junk_next;
    logic        ended_reg, ended_next;
    scan_snap_t  snap_reg, snap_next;

    logic [7:0]  c;
    logic        is_ws;
    logic        digit_ok;
    logic [3:0]  digit_val;
    logic        in_radix;
    logic [67:0] acc_wide;
    logic [67:0] prod;
    logic [67:0] sum;
    logic [7:0]  count_base;
    logic [7:0]  count_inc;

    always_comb
    begin
        c = item.text_char;
        is_ws = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);

        digit_ok = 1'b1;
        digit_val = 4'd0;
        if (c >= "0" && c <= "9")
        begin
            digit_val = 4'(c - "0");
        end
        else if (c >= "a" && c <= "f")
        begin
            digit_val = 4'(c - "a" + 8'd10);
        end
        else if (c >= "A" && c <= "F")
        begin
            digit_val = 4'(c - "A" + 8'd10);
        end
        else
        begin
            digit_ok = 1'b0;
        end
        in_radix = digit_ok && ({1'b0, digit_val} < radix_value(radix_reg));

        // constant-radix multiply as shifts, with one add for decimal
        acc_wide = {4'd0, acc_reg};
        unique case (radix_reg)
            RADIX_BIN: prod = acc_wide << 1;
            RADIX_OCT: prod = acc_wide << 3;
            RADIX_HEX: prod = acc_wide << 4;
            default:   prod = (acc_wide << 3) + (acc_wide << 1);
        endcase
        sum = prod + {64'd0, digit_val};

        // a lone leading zero counts as one digit already taken
        count_base = (phase_reg == PH_ZERO) ? 8'd1 : count_reg;
        count_inc  = (count_base == 8'd255) ? 8'd255 : count_base + 8'd1;

        phase_next    = phase_reg;
        negative_next = negative_reg;
        radix_next    = radix_reg;
        acc_next      = acc_reg;
        overflow_next = overflow_reg;
        count_next    = count_reg;
        bad_next      = bad_reg;
        junk_next     = junk_reg;
        ended_next    = ended_reg;

        if (!ended_reg)
        begin
            if (c == 8'd0)
            begin
                ended_next = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_LEAD, PH_SIGNED, PH_ZERO, PH_PREFIX, PH_RUN:
                    begin
                        if (phase_reg == PH_LEAD && is_ws)
                        begin
                            phase_next = PH_LEAD;
                        end
                        else if (phase_reg == PH_LEAD && (c == "+" || c == "-"))
                        begin
                            negative_next = (c == "-");
                            phase_next = PH_SIGNED;
                        end
                        else if ((phase_reg == PH_LEAD || phase_reg == PH_SIGNED)
                                 && c == "0")
                        begin
                            phase_next = PH_ZERO;
                        end
                        else if (phase_reg == PH_ZERO && (c == "b" || c == "B"))
                        begin
                            radix_next = RADIX_BIN;
                            phase_next = PH_PREFIX;
                        end
                        else if (phase_reg == PH_ZERO && (c == "o" || c == "O"))
                        begin
                            radix_next = RADIX_OCT;
                            phase_next = PH_PREFIX;
                        end
                        else if (phase_reg == PH_ZERO && (c == "x" || c == "X"))
                        begin
                            radix_next = RADIX_HEX;
                            phase_next = PH_PREFIX;
                        end
                        else if (is_ws)
                        begin
                            phase_next = PH_TRAIL;
                            count_next = count_base;
                        end
                        else
                        begin
                            phase_next = PH_RUN;
                            count_next = count_inc;
                            if (!in_radix)
                            begin
                                bad_next = 1'b1;
                            end
                            else if (!overflow_reg)
                            begin
                                if (|sum[67:64])
                                begin
                                    overflow_next = 1'b1;
                                end
                                else
                                begin
                                    acc_next = sum[63:0];
                                end
                            end
                        end
                    end
                    default:
                    begin
                        if (!is_ws)
                        begin
                            junk_next = 1'b1;
                        end
                    end
                endcase
            end
        end

        snap_next.early_done = 1'b1;
        unique case (phase_next)
            PH_LEAD:   snap_next.early_code = ERR_EMPTY;
            PH_SIGNED: snap_next.early_code = ERR_NO_DIGITS;
            PH_ZERO:   snap_next.early_code = ERR_NONE;
            PH_PREFIX: snap_next.early_code = ERR_PREFIX;
            default:
            begin
                snap_next.early_done = 1'b0;
                snap_next.early_code = ERR_NONE;
            end
        endcase
        snap_next.negative   = negative_next;
        snap_next.radix_code = radix_next;
        snap_next.magnitude  = acc_next;
        snap_next.overflow   = overflow_next;
        snap_next.count_zero = (count_next == 8'd0);
        snap_next.count_long = (count_next >= 8'(DIGIT_BUFFER_SIZE));
        snap_next.bad_digit  = bad_next;
        snap_next.junk       = junk_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_LEAD;
            negative_reg <= 1'b0;
            radix_reg    <= RADIX_DEC;
            acc_reg      <= 64'd0;
            overflow_reg <= 1'b0;
            count_reg    <= 8'd0;
            bad_reg      <= 1'b0;
            junk_reg     <= 1'b0;
            ended_reg    <= 1'b0;
        end
        else if (step)
        begin
            if (item.last_char)
            begin
                phase_reg    <= PH_LEAD;
                negative_reg <= 1'b0;
                radix_reg    <= RADIX_DEC;
                acc_reg      <= 64'd0;
                overflow_reg <= 1'b0;
                count_reg    <= 8'd0;
                bad_reg      <= 1'b0;
                junk_reg     <= 1'b0;
                ended_reg    <= 1'b0;
            end
            else
            begin
                phase_reg    <= phase_next;
                negative_reg <= negative_next;
                radix_reg    <= radix_next;
                acc_reg      <= acc_next;
                overflow_reg <= overflow_next;
                count_reg    <= count_next;
                bad_reg      <= bad_next;
                junk_reg     <= junk_next;
                ended_reg    <= ended_next;
            end
        end
    end

    // snapshot is payload only, valid is tracked by the caller
    always_ff @(posedge clk)
    begin
        if (step && item.last_char)
        begin
            snap_reg <= snap_next;
        end
    end

    assign snap = snap_reg;

endmodule

// ===== src/pitp_finish.sv =====
// ---------------------------------------------------------------------------
// pitp_finish: result from a field snapshot
// error priority, range check against the signed 64-bit limits and negation
// ---------------------------------------------------------------------------
module pitp_finish (
    input  pitp_pkg::scan_snap_t   snap,
    output pitp_pkg::result_item_t result
);
    import pitp_pkg::*;

    logic [2:0]  code;
    logic        range_bad;
    logic [63:0] value;

    always_comb
    begin
        // the most negative value is allowed only with a minus sign
        if (snap.negative)
        begin
            range_bad = snap.magnitude[63] && (|snap.magnitude[62:0]);
            value = 64'd0 - snap.magnitude;
        end
        else
        begin
            range_bad = snap.magnitude[63];
            value = snap.magnitude;
        end

        priority if (snap.early_done)
        begin
            code = snap.early_code;
        end
        else if (snap.junk)
        begin
            code = ERR_JUNK;
        end
        else if (snap.count_zero)
        begin
            code = ERR_NO_DIGITS;
        end
        else if (snap.count_long)
        begin
            code = ERR_TOO_LONG;
        end
        else if (snap.bad_digit)
        begin
            code = ERR_BAD_DIGIT;
        end
        else if (snap.overflow || range_bad)
        begin
            code = ERR_RANGE;
        end
        else
        begin
            code = ERR_NONE;
        end

        result.parse_ok       = (code == ERR_NONE);
        result.parsed_value   = (code == ERR_NONE && !snap.early_done) ? value : 64'd0;
        result.detected_radix = radix_value(snap.radix_code);
        result.error_code     = code;
    end

endmodule

// ===== src/prefixed_integer_text_parser.sv =====
// ---------------------------------------------------------------------------
// prefixed_integer_text_parser: signed integer from a stream of characters
// optional whitespace, sign and 0b/0o/0x prefix, digit run, trailing space
// ---------------------------------------------------------------------------
//
//  channel   valid          stall          payload
//  -------   ------------   ------------   ---------------------------
//  input     char_valid     char_stall     char_item   (char_item_t)
//  output    result_valid   result_stall   result_item (result_item_t)
//
//  one character is taken per cycle while char_stall is low; the accumulator
//  update is a shift-add on the registered character, so the scan loop sets
//  that rate; a field's result goes via the snapshot and output registers
//  reset clears the scan state and all valid flags; state also returns to
//  its start after every final character
//  a stalled result holds the output register; characters keep flowing until
//  a final character finds the snapshot stage still occupied
//
module prefixed_integer_text_parser (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    char_valid,
    output logic                    char_stall,
    input  pitp_pkg::char_item_t    char_item,
    output logic                    result_valid,
    input  logic                    result_stall,
    output pitp_pkg::result_item_t  result_item
);
    import pitp_pkg::*;

    logic         in_valid_reg, in_valid_next;
    char_item_t   in_item_reg;
    logic         snap_valid_reg, snap_valid_next;
    logic         out_valid_reg, out_valid_next;
    result_item_t out_item_reg;

    logic         out_free;
    logic         snap_free;
    logic         snap_move;
    logic         step;
    logic         accept;
    scan_snap_t   snap;
    result_item_t result;

    always_comb
    begin
        out_free  = !out_valid_reg || !result_stall;
        snap_free = !snap_valid_reg || out_free;
        snap_move = snap_valid_reg && out_free;
        // only a final character needs room in the snapshot stage
        step      = in_valid_reg && (!in_item_reg.last_char || snap_free);
        char_stall = in_valid_reg && !step;
        accept    = char_valid && !char_stall;

        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end

        snap_valid_next = snap_valid_reg;
        if (step && in_item_reg.last_char)
        begin
            snap_valid_next = 1'b1;
        end
        else if (snap_move)
        begin
            snap_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (snap_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            snap_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            snap_valid_reg <= snap_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= char_item;
        end
        if (snap_move)
        begin
            out_item_reg <= result;
        end
    end

    pitp_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (in_item_reg),
        .snap  (snap)
    );

    pitp_finish u_finish (
        .snap   (snap),
        .result (result)
    );

    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

endmodule

// ===== tb/sv/tb_prefixed_integer_text_parser.sv =====
// ---------------------------------------------------------------------------
// tb_prefixed_integer_text_parser: self-checking bench for the text parser
// feeds character items for whole fields, predicts each field's result and
// checks it field by field; directed table first, then random fields under
// several idle and stall mixes
// ---------------------------------------------------------------------------
module tb_prefixed_integer_text_parser;

    import pitp_pkg::*;

    typedef enum logic [2:0] {
        SCAN_LEAD,
        SCAN_SIGNED,
        SCAN_ZERO,
        SCAN_PREFIX,
        SCAN_RUN,
        SCAN_TRAIL
    } scan_phase_t;

    localparam logic [7:0] CH_0  = "0";
    localparam logic [7:0] CH_LA = "a";
    localparam logic [7:0] CH_UA = "A";
    localparam string BLANKS       = " \t\n\013\014\015";
    localparam string PREFIX_CHARS = "bBoOxX";
    localparam string NOISE_CHARS  = " +-xX0bBoO9fFgz";
    localparam int    RANDOM_CHARS = 1360;

    logic         clk;
    logic         rst_n;
    logic         char_valid;
    logic         char_stall;
    char_item_t   char_item;
    logic         result_valid;
    logic         result_stall;
    result_item_t result_item;

    prefixed_integer_text_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_item    (char_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    // parser state as the predictor sees it
    scan_phase_t scan_ph;
    logic        neg;
    logic [1:0]  rcode;
    logic [63:0] mag;
    logic        ovf;
    logic [7:0]  run_len;
    logic        bad_digit;
    logic        junk;
    logic        text_done;

    result_item_t parse_results_due[$];
    logic         pinned_on;
    result_item_t pinned_res;

    string        case_txt[$];
    int           case_nul[$];
    bit           case_pin[$];
    result_item_t case_want[$];

    int unsigned send_idle_pct;
    int unsigned stall_pct;
    int unsigned chars_sent;
    int unsigned fields_sent;
    int unsigned results_checked;
    int unsigned values_accepted;
    int unsigned mismatch_count;
    logic [7:0]  codes_seen;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("timeout with %0d results outstanding", parse_results_due.size());
        $display("FAILURE");
        $finish;
    end

    function automatic bit is_blank(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [6:0] digit_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return 7'(c - "0");
        if (c >= "a" && c <= "f")
            return 7'(c - "a" + 8'd10);
        if (c >= "A" && c <= "F")
            return 7'(c - "A" + 8'd10);
        return 7'd99;
    endfunction

    function automatic logic [63:0] base_of(input logic [1:0] code);
        case (code)
            RADIX_BIN: return 64'd2;
            RADIX_OCT: return 64'd8;
            RADIX_HEX: return 64'd16;
            default:   return 64'd10;
        endcase
    endfunction

    function automatic void clear_scan();
        scan_ph   = SCAN_LEAD;
        neg       = 1'b0;
        rcode     = RADIX_DEC;
        mag       = '0;
        ovf       = 1'b0;
        run_len   = '0;
        bad_digit = 1'b0;
        junk      = 1'b0;
        text_done = 1'b0;
    endfunction

    function automatic void accumulate(input logic [7:0] c);
        logic [63:0] r;
        logic [6:0]  d;
        r = base_of(rcode);
        d = digit_of(c);
        if (run_len != 8'd255)
            run_len = run_len + 8'd1;
        if (d >= r)
            bad_digit = 1'b1;
        else if (!ovf)
        begin
            // sticky: once the magnitude cannot grow it stays as it was
            if (mag > (64'hFFFF_FFFF_FFFF_FFFF - d) / r)
                ovf = 1'b1;
            else
                mag = mag * r + d;
        end
    endfunction

    function automatic void feed_run(input logic [7:0] c);
        if (is_blank(c))
            scan_ph = SCAN_TRAIL;
        else
        begin
            scan_ph = SCAN_RUN;
            accumulate(c);
        end
    endfunction

    function automatic result_item_t conclude_field();
        result_item_t res;
        logic [2:0]   err;
        logic [63:0]  v;
        v = '0;
        case (scan_ph)
            SCAN_LEAD:   err = ERR_EMPTY;
            SCAN_SIGNED: err = ERR_NO_DIGITS;
            SCAN_ZERO:   err = ERR_NONE;
            SCAN_PREFIX: err = ERR_PREFIX;
            default:
            begin
                if (junk)
                    err = ERR_JUNK;
                else if (run_len == 8'd0)
                    err = ERR_NO_DIGITS;
                else if (run_len >= DIGIT_BUFFER_SIZE)
                    err = ERR_TOO_LONG;
                else if (bad_digit)
                    err = ERR_BAD_DIGIT;
                else if (ovf)
                    err = ERR_RANGE;
                else if (neg && mag > 64'h8000_0000_0000_0000)
                    err = ERR_RANGE;
                else if (!neg && mag > 64'h7FFF_FFFF_FFFF_FFFF)
                    err = ERR_RANGE;
                else
                begin
                    err = ERR_NONE;
                    v   = neg ? -mag : mag;
                end
            end
        endcase
        res.parse_ok       = (err == ERR_NONE);
        res.parsed_value   = v;
        res.detected_radix = 5'(base_of(rcode));
        res.error_code     = err;
        clear_scan();
        return res;
    endfunction

    // called at the edge where a character item is taken
    task automatic track_char(input char_item_t it);
        result_item_t res;
        logic [7:0]   c;
        c = it.text_char;
        if (!text_done)
        begin
            if (c == 8'd0)
                text_done = 1'b1;
            else
            begin
                case (scan_ph)
                    SCAN_LEAD:
                    begin
                        if (c == "+" || c == "-")
                        begin
                            neg     = (c == "-");
                            scan_ph = SCAN_SIGNED;
                        end
                        else if (c == CH_0)
                            scan_ph = SCAN_ZERO;
                        else if (!is_blank(c))
                            feed_run(c);
                    end
                    SCAN_SIGNED:
                    begin
                        if (c == CH_0)
                            scan_ph = SCAN_ZERO;
                        else
                            feed_run(c);
                    end
                    SCAN_ZERO:
                    begin
                        if (c == "b" || c == "B")
                        begin
                            rcode   = RADIX_BIN;
                            scan_ph = SCAN_PREFIX;
                        end
                        else if (c == "o" || c == "O")
                        begin
                            rcode   = RADIX_OCT;
                            scan_ph = SCAN_PREFIX;
                        end
                        else if (c == "x" || c == "X")
                        begin
                            rcode   = RADIX_HEX;
                            scan_ph = SCAN_PREFIX;
                        end
                        else
                        begin
                            // the leading zero was a digit after all
                            accumulate(CH_0);
                            feed_run(c);
                        end
                    end
                    SCAN_PREFIX, SCAN_RUN:
                        feed_run(c);
                    default:
                    begin
                        if (!is_blank(c))
                            junk = 1'b1;
                    end
                endcase
            end
        end
        if (it.last_char)
        begin
            res = conclude_field();
            if (pinned_on)
                res = pinned_res;
            parse_results_due.push_back(res);
        end
    endtask

    // entered and left at a falling edge
    task automatic send_char(input char_item_t it);
        if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            char_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99, 0) < send_idle_pct);
        end
        char_valid <= 1'b1;
        char_item  <= it;
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        track_char(it);
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_field(input logic [7:0] chars[$]);
        char_item_t it;
        for (int i = 0; i < chars.size(); i++)
        begin
            it.text_char = chars[i];
            it.last_char = (i == chars.size() - 1);
            send_char(it);
        end
        fields_sent++;
    endtask

    // sender holds off until every outstanding result is back
    task automatic pause_until_drained();
        char_valid <= 1'b0;
        @(negedge clk);
        while (parse_results_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic add_case(input string txt, input int nul_at, input bit pin,
                            input logic ok, input logic signed [63:0] val,
                            input logic [4:0] rad, input logic [2:0] err);
        result_item_t w;
        w.parse_ok       = ok;
        w.parsed_value   = val;
        w.detected_radix = rad;
        w.error_code     = err;
        case_txt.push_back(txt);
        case_nul.push_back(nul_at);
        case_pin.push_back(pin);
        case_want.push_back(w);
    endtask

    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            result_stall <= (stall_pct != 0 && $urandom_range(99, 0) < stall_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        result_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (parse_results_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display({"%0t: result with no field pending: ",
                              "ok=%0b value=%0d radix=%0d err=%0d"},
                             $time, result_item.parse_ok, result_item.parsed_value,
                             result_item.detected_radix, result_item.error_code);
            end
            else
            begin
                want = parse_results_due.pop_front();
                if (result_item.parse_ok !== want.parse_ok
                    || result_item.parsed_value !== want.parsed_value
                    || result_item.detected_radix !== want.detected_radix
                    || result_item.error_code !== want.error_code)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"%0t: mismatch: expected ok=%0b value=%0d radix=%0d ",
                                  "err=%0d, got ok=%0b value=%0d radix=%0d err=%0d"},
                                 $time, want.parse_ok, want.parsed_value,
                                 want.detected_radix, want.error_code,
                                 result_item.parse_ok, result_item.parsed_value,
                                 result_item.detected_radix, result_item.error_code);
                end
                results_checked++;
            end
            if (result_item.parse_ok === 1'b1)
                values_accepted++;
            codes_seen[result_item.error_code] = 1'b1;
        end
    end

    initial
    begin : stimulus
        string       s;
        string       zeros;
        logic [7:0]  fld[$];
        logic [1:0]  rc;
        int          base;
        int          cap;
        int          ndig;
        int          dv;
        int          pos;
        int unsigned target;
        int unsigned idle_plan[4];
        int unsigned stall_plan[4];

        rst_n           = 1'b0;
        char_valid      = 1'b0;
        char_item       = '0;
        send_idle_pct   = 0;
        stall_pct       = 0;
        chars_sent      = 0;
        fields_sent     = 0;
        results_checked = 0;
        values_accepted = 0;
        mismatch_count  = 0;
        codes_seen      = '0;
        pinned_on       = 1'b0;
        pinned_res      = '0;
        clear_scan();
        idle_plan  = '{0, 59, 0, 25};
        stall_plan = '{0, 0, 59, 25};

        zeros = "";
        repeat (127)
            zeros = {zeros, "0"};

        add_case("0", -1, 1, 1'b1, 64'sd0, 5'd10, ERR_NONE);
        add_case(" ", 0, 1, 1'b0, 64'sd0, 5'd10, ERR_EMPTY);
        add_case(BLANKS, -1, 1, 1'b0, 64'sd0, 5'd10, ERR_EMPTY);
        add_case("-", -1, 1, 1'b0, 64'sd0, 5'd10, ERR_NO_DIGITS);
        add_case("- ", -1, 1, 1'b0, 64'sd0, 5'd10, ERR_NO_DIGITS);
        add_case("+0x", -1, 1, 1'b0, 64'sd0, 5'd16, ERR_PREFIX);
        add_case("0b", -1, 1, 1'b0, 64'sd0, 5'd2, ERR_PREFIX);
        add_case("9223372036854775807", -1, 1, 1'b1, 64'sh7FFF_FFFF_FFFF_FFFF, 5'd10,
                 ERR_NONE);
        add_case("-9223372036854775808", -1, 1, 1'b1, 64'sh8000_0000_0000_0000, 5'd10,
                 ERR_NONE);
        add_case("9223372036854775808", -1, 1, 1'b0, 64'sd0, 5'd10, ERR_RANGE);
        add_case("-9223372036854775809", -1, 1, 1'b0, 64'sd0, 5'd10, ERR_RANGE);
        add_case("0xFFFFFFFFFFFFFFFF", -1, 1, 1'b0, 64'sd0, 5'd16, ERR_RANGE);
        add_case("0x10000000000000000", -1, 1, 1'b0, 64'sd0, 5'd16, ERR_RANGE);
        add_case("  -0b1011 \t", -1, 1, 1'b1, -64'sd11, 5'd2, ERR_NONE);
        add_case("0O777", -1, 1, 1'b1, 64'sd511, 5'd8, ERR_NONE);
        add_case("+0x1f2E", -1, 0, 1'b0, 64'sd0, 5'd0, ERR_NONE);
        add_case("-0o17 ", -1, 0, 1'b0, 64'sd0, 5'd0, ERR_NONE);
        add_case("12 3", -1, 1, 1'b0, 64'sd0, 5'd10, ERR_JUNK);
        add_case("0x 5", -1, 1, 1'b0, 64'sd0, 5'd16, ERR_JUNK);
        add_case("12x", -1, 1, 1'b0, 64'sd0, 5'd10, ERR_BAD_DIGIT);
        add_case("1-2", -1, 1, 1'b0, 64'sd0, 5'd10, ERR_BAD_DIGIT);
        add_case("0b102", -1, 1, 1'b0, 64'sd0, 5'd2, ERR_BAD_DIGIT);
        add_case("12?zz", 2, 1, 1'b1, 64'sd12, 5'd10, ERR_NONE);
        add_case("\377", -1, 1, 1'b0, 64'sd0, 5'd10, ERR_BAD_DIGIT);
        add_case(zeros, -1, 1, 1'b1, 64'sd0, 5'd10, ERR_NONE);
        add_case({zeros, "0"}, -1, 1, 1'b0, 64'sd0, 5'd10, ERR_TOO_LONG);

        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        for (int k = 0; k < case_txt.size(); k++)
        begin
            s = case_txt[k];
            fld.delete();
            for (int i = 0; i < s.len(); i++)
                fld.push_back((i == case_nul[k]) ? 8'd0 : s[i]);
            pinned_on  = case_pin[k];
            pinned_res = case_want[k];
            send_field(fld);
        end
        pinned_on = 1'b0;
        pause_until_drained();

        // random fields, mostly well formed, some broken
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = idle_plan[p];
            stall_pct     = stall_plan[p];
            target        = chars_sent + RANDOM_CHARS / 4;
            while (chars_sent < target)
            begin
                fld.delete();
                repeat ($urandom_range(2, 0))
                    fld.push_back(BLANKS[$urandom_range(5, 0)]);
                case ($urandom_range(2, 0))
                    1: fld.push_back("+");
                    2: fld.push_back("-");
                    default: ;
                endcase
                rc = 2'($urandom_range(3, 0));
                if (rc != RADIX_DEC)
                begin
                    fld.push_back(CH_0);
                    fld.push_back(PREFIX_CHARS[2 * (rc - 1) + $urandom_range(1, 0)]);
                end
                case (rc)
                    RADIX_BIN: begin base = 2;  cap = 66; end
                    RADIX_OCT: begin base = 8;  cap = 24; end
                    RADIX_HEX: begin base = 16; cap = 18; end
                    default:   begin base = 10; cap = 21; end
                endcase
                ndig = ($urandom_range(7, 0) == 0) ? $urandom_range(3, 1)
                                                    : $urandom_range(cap, 1);
                // now and then a run around the length limit
                if ($urandom_range(39, 0) == 0)
                    ndig = $urandom_range(132, 124);
                repeat (ndig)
                begin
                    dv = $urandom_range(base - 1, 0);
                    if (dv < 10)
                        fld.push_back(8'(CH_0 + dv));
                    else
                        fld.push_back(8'(($urandom_range(1, 0) ? CH_LA : CH_UA) + dv - 10));
                end
                repeat ($urandom_range(2, 0))
                    fld.push_back(BLANKS[$urandom_range(5, 0)]);

                if ($urandom_range(3, 0) == 0)
                begin
                    case ($urandom_range(4, 0))
                        0:
                            fld[$urandom_range(fld.size() - 1, 0)] =
                                8'($urandom_range(255, 0));
                        1:
                        begin
                            fld.insert($urandom_range(fld.size(), 0), 8'd0);
                            repeat ($urandom_range(3, 0))
                                fld.push_back(8'($urandom_range(255, 0)));
                        end
                        2:
                        begin
                            fld.delete();
                            repeat ($urandom_range(8, 1))
                                fld.push_back(8'($urandom_range(255, 0)));
                        end
                        3:
                        begin
                            pos = $urandom_range(fld.size(), 0);
                            while (fld.size() > pos)
                                void'(fld.pop_back());
                        end
                        default:
                            fld.insert($urandom_range(fld.size(), 0),
                                       NOISE_CHARS[$urandom_range(NOISE_CHARS.len() - 1, 0)]);
                    endcase
                end
                if (fld.size() == 0)
                    fld.push_back(8'($urandom_range(255, 0)));
                send_field(fld);
            end
            pause_until_drained();
        end

        repeat (10)
            @(posedge clk);
        if (parse_results_due.size() != 0)
        begin
            $display("%0d results never arrived", parse_results_due.size());
            mismatch_count += parse_results_due.size();
        end
        $display("run covered %0d characters in %0d fields under four idle/stall mixes",
                 chars_sent, fields_sent);
        $display("%0d results checked, %0d valid integers, error codes seen (bit per code) %b",
                 results_checked, values_accepted, codes_seen);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/pitp_pkg.sv
src/pitp_scan.sv
src/pitp_finish.sv
src/prefixed_integer_text_parser.sv
tb/sv/tb_prefixed_integer_text_parser.sv
